>>> rtl/core/pbvc_pkg.sv
// Shared types and constants for the port bit-vector classifier stage.
// No dependencies.
package pbvc_pkg;

	localparam logic [1:0] ACT_PACKET = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_INVAL  = 2'd2;
	localparam logic [1:0] ACT_COUNT  = 2'd3;

	localparam logic [2:0] KIND_LOOKUP = 3'd0;
	localparam logic [2:0] KIND_PASS   = 3'd1;
	localparam logic [2:0] KIND_WRITE  = 3'd2;
	localparam logic [2:0] KIND_INVAL  = 3'd3;
	localparam logic [2:0] KIND_COUNT  = 3'd4;

	localparam logic [1:0] VERDICT_NONE   = 2'd0;
	localparam logic [1:0] VERDICT_NEXT   = 2'd1;
	localparam logic [1:0] VERDICT_ACCEPT = 2'd2;
	localparam logic [1:0] VERDICT_DROP   = 2'd3;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [1:0] CNT_PACKETS = 2'd0;
	localparam logic [1:0] CNT_BYTES   = 2'd1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] key;
		logic [1:0]  wi;
		logic [63:0] data;
		logic        last;
		logic [15:0] plen;
	} cmd_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} back_status_t;

endpackage

>>> rtl/core/pbvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbvc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/pbvc_front.sv
// Front part: accepts input beats, classifies them, queues them in two entries.
// Depends on pbvc_pkg.
module pbvc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hold,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    action,
	input  logic [7:0]    protocol,
	input  logic [15:0]   port,
	input  logic [1:0]    word_index,
	input  logic [63:0]   data_word,
	input  logic          last_word,
	input  logic [15:0]   packet_length,
	output logic          q_valid,
	output pbvc_pkg::cmd_t q_cmd,
	input  logic          pop
);
	import pbvc_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       accept;
	cmd_t       cmd_in;

	always_comb begin
		cmd_in.key  = port;
		cmd_in.wi   = word_index;
		cmd_in.data = data_word;
		cmd_in.last = last_word;
		cmd_in.plen = packet_length;
		unique case (action)
			ACT_PACKET: cmd_in.kind = (protocol == PROTO_TCP || protocol == PROTO_UDP)
				? KIND_LOOKUP : KIND_PASS;
			ACT_WRITE:  cmd_in.kind = KIND_WRITE;
			ACT_INVAL:  cmd_in.kind = KIND_INVAL;
			default:    cmd_in.kind = KIND_COUNT;
		endcase
	end

	assign in_stall = (count_q == 2'd2) || hold;
	assign accept   = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_cmd    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(accept) - 2'(pop);
		end
	end
endmodule

>>> rtl/core/pbvc_back.sv
// Back part: table lookups, AND, counters, table updates, output register.
// Depends on pbvc_pkg and pbvc_ram.
module pbvc_back #(
	parameter int PORT_BITS    = 16,
	parameter int VECTOR_WORDS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  default_accept,
	input  logic                  q_valid,
	input  pbvc_pkg::cmd_t        q_cmd,
	output pbvc_pkg::back_status_t status,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [63:0]           word_out,
	output logic [1:0]            verdict,
	output logic                  last
);
	import pbvc_pkg::*;

	localparam int WIB     = (VECTOR_WORDS > 1) ? $clog2(VECTOR_WORDS) : 1;
	localparam int VADDR   = PORT_BITS + WIB;
	localparam int ENTRIES = 1 << PORT_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_VK   = 3'd1;
	localparam logic [2:0] S_V0   = 3'd2;
	localparam logic [2:0] S_VEC  = 3'd3;
	localparam logic [2:0] S_RES  = 3'd4;

	logic [2:0]         state_q;
	cmd_t               cmd_q;
	logic               hit_q;
	logic               any_q;
	logic [63:0]        pkt_cnt_q;
	logic [63:0]        byte_cnt_q;
	logic [PORT_BITS:0] clr_q;
	logic [63:0]        res_word_q;
	logic [1:0]         res_verdict_q;
	logic               res_last_q;
	logic               out_valid_q;
	logic [63:0]        out_word_q;
	logic [1:0]         out_verdict_q;
	logic               out_last_q;

	logic                 clearing;
	logic                 pop;
	logic                 load_out;
	logic                 v_we;
	logic [PORT_BITS-1:0] v_waddr;
	logic                 v_wdata;
	logic [PORT_BITS-1:0] v_raddr;
	logic                 v_rdata;
	logic                 vec_we;
	logic [VADDR-1:0]     vec_waddr;
	logic [VADDR-1:0]     vec_raddr;
	logic [63:0]          vec_rdata;
	logic [WIB+1:0]       q_wi_x;
	logic [WIB+1:0]       c_wi_x;
	logic                 q_wi_ok;
	logic                 c_wi_ok;
	logic [63:0]          and_word;
	logic                 any_now;

	assign clearing = !clr_q[PORT_BITS];
	assign pop      = (state_q == S_IDLE) && q_valid && !clearing;
	assign load_out = (state_q == S_RES) && (!out_valid_q || !out_stall);
	assign status   = '{clearing: clearing, pop: pop};

	assign q_wi_x  = (WIB+2)'(q_cmd.wi);
	assign c_wi_x  = (WIB+2)'(cmd_q.wi);
	assign q_wi_ok = int'(q_cmd.wi) < VECTOR_WORDS;
	assign c_wi_ok = int'(cmd_q.wi) < VECTOR_WORDS;

	assign and_word = (hit_q && c_wi_ok) ? (cmd_q.data & vec_rdata) : 64'd0;
	assign any_now  = any_q || (and_word != 64'd0);

	always_comb begin
		v_we    = 1'b0;
		v_waddr = q_cmd.key[PORT_BITS-1:0];
		v_wdata = 1'b0;
		vec_we  = 1'b0;
		if (clearing) begin
			v_we    = 1'b1;
			v_waddr = clr_q[PORT_BITS-1:0];
		end else if (pop && q_cmd.kind == KIND_WRITE && q_wi_ok) begin
			v_we    = 1'b1;
			v_wdata = 1'b1;
			vec_we  = 1'b1;
		end else if (pop && q_cmd.kind == KIND_INVAL) begin
			v_we = 1'b1;
		end
	end

	assign vec_waddr = {q_cmd.key[PORT_BITS-1:0], q_wi_x[WIB-1:0]};
	assign v_raddr   = (state_q == S_VK) ? '0 : q_cmd.key[PORT_BITS-1:0];
	assign vec_raddr = (state_q == S_VK) ? {cmd_q.key[PORT_BITS-1:0], c_wi_x[WIB-1:0]}
		: {{PORT_BITS{1'b0}}, c_wi_x[WIB-1:0]};

	pbvc_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_valid_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	pbvc_ram #(.WIDTH(64), .DEPTH(1 << VADDR)) u_vec_ram (
		.clk   (clk),
		.we    (vec_we),
		.waddr (vec_waddr),
		.wdata (q_cmd.data),
		.raddr (vec_raddr),
		.rdata (vec_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hit_q       <= 1'b0;
			any_q       <= 1'b0;
			pkt_cnt_q   <= 64'd0;
			byte_cnt_q  <= 64'd0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + {{PORT_BITS{1'b0}}, 1'b1};
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= (q_cmd.kind == KIND_LOOKUP) ? S_VK : S_RES;
					end
				end
				S_VK: begin
					hit_q   <= v_rdata;
					state_q <= v_rdata ? S_VEC : S_V0;
				end
				S_V0: begin
					hit_q   <= v_rdata;
					state_q <= S_VEC;
				end
				S_VEC: begin
					state_q <= S_RES;
					if (!cmd_q.last) begin
						any_q <= any_now;
					end else begin
						any_q <= 1'b0;
						if (!(hit_q && any_now)) begin
							pkt_cnt_q  <= pkt_cnt_q + 64'd1;
							byte_cnt_q <= byte_cnt_q + 64'(cmd_q.plen);
						end
					end
				end
				S_RES: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
			unique case (q_cmd.kind)
				KIND_PASS: begin
					res_word_q    <= q_cmd.data;
					res_verdict_q <= q_cmd.last ? VERDICT_NEXT : VERDICT_NONE;
					res_last_q    <= q_cmd.last;
				end
				KIND_COUNT: begin
					if (q_cmd.wi == CNT_PACKETS) begin
						res_word_q <= pkt_cnt_q;
					end else if (q_cmd.wi == CNT_BYTES) begin
						res_word_q <= byte_cnt_q;
					end else begin
						res_word_q <= 64'd0;
					end
					res_verdict_q <= VERDICT_NONE;
					res_last_q    <= 1'b0;
				end
				default: begin
					res_word_q    <= 64'd0;
					res_verdict_q <= VERDICT_NONE;
					res_last_q    <= 1'b0;
				end
			endcase
		end
		if (state_q == S_VEC) begin
			res_word_q <= and_word;
			res_last_q <= cmd_q.last;
			if (!cmd_q.last) begin
				res_verdict_q <= VERDICT_NONE;
			end else if (hit_q && any_now) begin
				res_verdict_q <= VERDICT_NEXT;
			end else begin
				res_verdict_q <= default_accept ? VERDICT_ACCEPT : VERDICT_DROP;
			end
		end
		if (load_out) begin
			out_word_q    <= res_word_q;
			out_verdict_q <= res_verdict_q;
			out_last_q    <= res_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign word_out  = out_word_q;
	assign verdict   = out_verdict_q;
	assign last      = out_last_q;
endmodule

>>> rtl/core/port_bitvector_classifier_stage.sv
// Port bit-vector classifier stage: top level, front queue plus back sequencer.
// Table, counter and non-TCP/UDP packet beats go straight to the result register; TCP and UDP
// packet beats step through valid read, wildcard valid read on a miss, vector read, result.
// The back takes one beat at a time and pops the next only after the last result is
// loaded into the output register. Front queue holds two beats.
// Reset: asynchronous; afterwards the valid table is cleared, entry by entry, while input stalls.
module port_bitvector_classifier_stage #(
	parameter int VECTOR_WORDS = 4,
	parameter int PORT_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  protocol,
	input  logic [15:0] port,
	input  logic [1:0]  word_index,
	input  logic [63:0] data_word,
	input  logic        last_word,
	input  logic [15:0] packet_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] word_out,
	output logic [1:0]  verdict,
	output logic        last
);
	import pbvc_pkg::*;

	logic         default_accept_q;
	logic         q_valid;
	cmd_t         q_cmd;
	back_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_accept_q <= 1'b0;
		end else if (cfg_wr_en) begin
			default_accept_q <= cfg_wr_data;
		end
	end

	pbvc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.hold          (status.clearing),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.protocol      (protocol),
		.port          (port),
		.word_index    (word_index),
		.data_word     (data_word),
		.last_word     (last_word),
		.packet_length (packet_length),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.pop           (status.pop)
	);

	pbvc_back #(.PORT_BITS(PORT_BITS), .VECTOR_WORDS(VECTOR_WORDS)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.default_accept (default_accept_q),
		.q_valid        (q_valid),
		.q_cmd          (q_cmd),
		.status         (status),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.word_out       (word_out),
		.verdict        (verdict),
		.last           (last)
	);

	a_last_has_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (verdict != VERDICT_NONE)))
		else $error("last flag and verdict disagree");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!status.clearing |=> !status.clearing)
		else $error("valid table clear restarted");

	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !out_valid)
		else $error("result during valid table clear");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		status.pop |-> q_valid)
		else $error("pop from empty queue");
endmodule

>>> bench/port_bitvector_classifier_stage_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the port bit-vector classifier stage: a directed table, then
// random packet streams, table updates and counter reads, checked against a local model.
// Depends on pbvc_pkg and port_bitvector_classifier_stage.
module port_bitvector_classifier_stage_test;
	import pbvc_pkg::*;

	typedef struct {
		logic [1:0]  act;
		logic [7:0]  proto;
		logic [15:0] prt;
		logic [1:0]  wi;
		logic [63:0] data;
		logic        lw;
		logic [15:0] plen;
	} beat_t;

	typedef struct {
		logic [63:0] word;
		logic [1:0]  vd;
		logic        lst;
	} result_t;

	typedef struct {
		beat_t   b;
		logic    known;
		result_t r;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic cfg_wr_data = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] action = '0;
	logic [7:0] protocol = '0;
	logic [15:0] port = '0;
	logic [1:0] word_index = '0;
	logic [63:0] data_word = '0;
	logic last_word = 0;
	logic [15:0] packet_length = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [63:0] word_out;
	logic [1:0] verdict;
	logic last;

	port_bitvector_classifier_stage dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .action(action), .protocol(protocol),
		.port(port), .word_index(word_index), .data_word(data_word),
		.last_word(last_word), .packet_length(packet_length), .out_valid(out_valid),
		.out_stall(out_stall), .word_out(word_out), .verdict(verdict), .last(last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// classifier model state
	logic        accept_default;
	bit          entry_ok [int];
	logic [63:0] vec_store [int];
	bit          written [int];
	logic        seen_bit;
	logic [63:0] pkt_count, byte_count;

	result_t     pending [$];
	int          errors = 0;
	int          idle_cycles = 0;
	int          long_hold = 0;
	bit          in_pkt = 0;
	int          pkt_port;
	logic [7:0]  pkt_proto;
	int          ports [$];

	function automatic result_t classify(beat_t b);
		result_t r;
		int key;
		bit hit;
		logic [63:0] w;
		r = '{64'd0, VERDICT_NONE, 1'b0};
		key = b.prt;
		case (b.act)
			ACT_WRITE: begin
				vec_store[key * 4 + b.wi] = b.data;
				written[key * 4 + b.wi] = 1;
				entry_ok[key] = 1;
			end
			ACT_INVAL: entry_ok[key] = 0;
			ACT_COUNT: begin
				if (b.wi == CNT_PACKETS) r.word = pkt_count;
				else if (b.wi == CNT_BYTES) r.word = byte_count;
			end
			default: begin
				if (b.proto != PROTO_TCP && b.proto != PROTO_UDP) begin
					r.word = b.data;
					r.vd = b.lw ? VERDICT_NEXT : VERDICT_NONE;
					r.lst = b.lw;
				end else begin
					hit = 1;
					if (!entry_ok.exists(key) || !entry_ok[key]) begin
						key = 0;
						if (!entry_ok.exists(0) || !entry_ok[0]) hit = 0;
					end
					w = 0;
					if (hit && vec_store.exists(key * 4 + b.wi))
						w = b.data & vec_store[key * 4 + b.wi];
					if (w != 0) seen_bit = 1;
					r.word = w;
					if (b.lw) begin
						r.lst = 1;
						if (hit && seen_bit) r.vd = VERDICT_NEXT;
						else begin
							pkt_count += 1;
							byte_count += b.plen;
							r.vd = accept_default ? VERDICT_ACCEPT : VERDICT_DROP;
						end
						seen_bit = 0;
					end
				end
			end
		endcase
		return r;
	endfunction

	// true when no lookup of this port can read a never-written word
	function automatic bit port_safe(int p);
		int k;
		k = p;
		if (!entry_ok.exists(k) || !entry_ok[k]) begin
			k = 0;
			if (!entry_ok.exists(0) || !entry_ok[0]) return 1;
		end
		for (int i = 0; i < 4; i++)
			if (!written.exists(k * 4 + i)) return 0;
		return 1;
	endfunction

	function automatic int gap_len();
		int g;
		g = $urandom_range(0, 99);
		if (g < 45) return 0;
		if (g < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send(beat_t b, bit known = 0, result_t want = '{64'd0, 2'd0, 1'b0});
		result_t r;
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		action <= b.act;
		protocol <= b.proto;
		port <= b.prt;
		word_index <= b.wi;
		data_word <= b.data;
		last_word <= b.lw;
		packet_length <= b.plen;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = classify(b);
		if (known && r != want) begin
			$error("table row disagrees with model: word %h verdict %0d", r.word, r.vd);
			errors++;
		end
		pending.push_back(r);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_default(logic v);
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 0;
		accept_default = v;
	endtask

	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				$error("unexpected result word %h", word_out);
				errors++;
			end else begin
				e = pending.pop_front();
				if (word_out !== e.word) begin
					$error("word_out expected %h actual %h", e.word, word_out);
					errors++;
				end
				if (verdict !== e.vd) begin
					$error("verdict expected %0d actual %0d", e.vd, verdict);
					errors++;
				end
				if (last !== e.lst) begin
					$error("last expected %0d actual %0d", e.lst, last);
					errors++;
				end
			end
		end
	end

	// receiver stalls, with one long hold
	always @(posedge clk) begin
		if (long_hold > 0) begin
			out_stall <= 1;
			long_hold <= long_hold - 1;
		end else begin
			out_stall <= (gap_len() > 0) && ($urandom_range(0, 2) == 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 200000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic beat_t mk(logic [1:0] a, logic [7:0] pr, logic [15:0] p,
		logic [1:0] w, logic [63:0] d, logic l, logic [15:0] n);
		beat_t b;
		b = '{a, pr, p, w, d, l, n};
		return b;
	endfunction

	function automatic int pick_port();
		if (ports.size() != 0 && $urandom_range(0, 3) != 0)
			return ports[$urandom_range(0, ports.size() - 1)];
		return $urandom_range(0, 65535);
	endfunction

	initial begin
		row_t rows [$];
		beat_t b;
		int n, p, wl;
		logic [7:0] pr;
		accept_default = 0;
		seen_bit = 0;
		pkt_count = 0;
		byte_count = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table
		rows.push_back('{mk(ACT_COUNT, 0, 0, CNT_PACKETS, 0, 0, 0), 1, '{0, VERDICT_NONE, 0}});
		rows.push_back('{mk(ACT_PACKET, PROTO_TCP, 16'hFFFF, 0, '1, 0, 0), 1,
			'{0, VERDICT_NONE, 0}});
		rows.push_back('{mk(ACT_PACKET, PROTO_TCP, 16'hFFFF, 3, '1, 1, 16'hFFFF), 1,
			'{0, VERDICT_DROP, 1}});
		rows.push_back('{mk(ACT_PACKET, 8'hFF, 16'h1234, 0, '1, 1, 0), 1,
			'{'1, VERDICT_NEXT, 1}});
		rows.push_back('{mk(ACT_PACKET, 8'd0, 0, 2, 64'hA5, 0, 0), 1,
			'{64'hA5, VERDICT_NONE, 0}});
		rows.push_back('{mk(ACT_COUNT, 0, 0, CNT_PACKETS, 0, 0, 0), 1, '{1, VERDICT_NONE, 0}});
		rows.push_back('{mk(ACT_COUNT, 0, 0, CNT_BYTES, 0, 0, 0), 1,
			'{64'hFFFF, VERDICT_NONE, 0}});
		rows.push_back('{mk(ACT_COUNT, 0, 0, 2'd3, 0, 0, 0), 1, '{0, VERDICT_NONE, 0}});
		for (int i = 0; i < 4; i++) begin
			rows.push_back('{mk(ACT_WRITE, 0, 0, 2'(i), 64'h0F0F << i, 0, 0), 1,
				'{0, VERDICT_NONE, 0}});
			rows.push_back('{mk(ACT_WRITE, 0, 16'hFFFF, 2'(i), '1, 0, 0), 1,
				'{0, VERDICT_NONE, 0}});
		end
		rows.push_back('{mk(ACT_PACKET, PROTO_UDP, 16'hFFFF, 0, 64'h00FF, 0, 0), 0, '{0, 0, 0}});
		rows.push_back('{mk(ACT_PACKET, PROTO_UDP, 16'hFFFF, 1, 0, 1, 7), 0, '{0, 0, 0}});
		rows.push_back('{mk(ACT_PACKET, PROTO_TCP, 16'd80, 0, '1, 1, 100), 0, '{0, 0, 0}});
		rows.push_back('{mk(ACT_INVAL, 0, 16'hFFFF, 0, 0, 0, 0), 1, '{0, VERDICT_NONE, 0}});
		rows.push_back('{mk(ACT_PACKET, PROTO_TCP, 16'hFFFF, 0, 64'hF0F0, 1, 5), 0, '{0, 0, 0}});
		rows.push_back('{mk(ACT_PACKET, PROTO_TCP, 16'hFFFF, 1, 64'h1E1E, 1, 5), 0, '{0, 0, 0}});
		rows.push_back('{mk(ACT_COUNT, 0, 0, CNT_BYTES, 0, 0, 0), 0, '{0, 0, 0}});
		foreach (rows[i]) send(rows[i].b, rows[i].known, rows[i].r);
		drain();
		set_default(1);
		ports.push_back(0);
		ports.push_back(32'hFFFF);

		// fill up the block behind a long receiver hold
		long_hold = 300;
		for (int i = 0; i < 12; i++)
			send(mk(ACT_PACKET, 8'd1, 16'($urandom), 2'($urandom), {$urandom, $urandom},
				i % 3 == 2, 0));
		drain();

		// random phases, default action set at random between them
		n = 0;
		while (n < 450) begin
			if (n % 110 == 100) begin
				if (in_pkt) begin
					send(mk(ACT_PACKET, pkt_proto, 16'(pkt_port), 0, {$urandom, $urandom}, 1,
						16'($urandom)));
					in_pkt = 0;
				end
				drain();
				set_default(1'($urandom_range(0, 1)));
			end
			case ($urandom_range(0, 9))
				0, 1: begin
					p = pick_port();
					b = mk(ACT_WRITE, 8'($urandom), 16'(p), 2'($urandom), {$urandom, $urandom},
						1'($urandom), 16'($urandom));
					if ($urandom_range(0, 3) == 0) b.data = '0;
					if (!in_pkt && $urandom_range(0, 1) == 0) begin
						for (int i = 0; i < 4; i++) begin
							b.wi = 2'(i);
							b.data = {$urandom, $urandom};
							send(b);
							n++;
						end
						ports.push_back(p);
					end else if (written.exists(p * 4) && written.exists(p * 4 + 1) &&
						written.exists(p * 4 + 2) && written.exists(p * 4 + 3)) begin
						send(b);
						n++;
					end
				end
				2: begin
					p = pick_port();
					send(mk(ACT_INVAL, 8'($urandom), 16'(p), 2'($urandom), {$urandom, $urandom},
						1'($urandom), 16'($urandom)));
					n++;
				end
				3: begin
					send(mk(ACT_COUNT, 8'($urandom), 16'($urandom), 2'($urandom),
						{$urandom, $urandom}, 1'($urandom), 16'($urandom)));
					n++;
				end
				default: begin
					wl = $urandom_range(1, 4);
					p = pick_port();
					pr = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
						($urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP);
					if (port_safe(p)) begin
						for (int i = 0; i < wl; i++) begin
							b = mk(ACT_PACKET, pr, 16'(p),
								$urandom_range(0, 5) == 0 ? 2'($urandom) : 2'(i),
								{$urandom, $urandom}, i == wl - 1, 16'($urandom));
							if ($urandom_range(0, 4) == 0) b.data = '1;
							send(b);
							n++;
						end
					end
				end
			endcase
		end
		drain();
		drain();
		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule

>>> sim.f
rtl/core/pbvc_pkg.sv
rtl/core/pbvc_ram.sv
rtl/core/pbvc_front.sv
rtl/core/pbvc_back.sv
rtl/core/port_bitvector_classifier_stage.sv
bench/port_bitvector_classifier_stage_test.sv
